// File: src/cds_pkg.sv
package cds_pkg;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVALID  = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// operation codes
	localparam logic OP_ADD_DAY   = 1'b0;
	localparam logic OP_ADD_MONTH = 1'b1;

	// accepted text lengths
	localparam logic [3:0] LEN_LONG  = 4'd8;
	localparam logic [3:0] LEN_SHORT = 4'd6;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_ONE  = 8'h31;

	// four bcd digits of a year, thousands in the top nibble
	typedef logic [15:0] year_bcd_t;

	// gregorian leap rule worked on bcd digits
	function automatic logic bcd_leap(input year_bcd_t y);
		logic yy_div4;
		logic yy_zero;
		logic cc_div4;
		logic [1:0] s_yy;
		logic [1:0] s_cc;
		begin
			// 10*t + o mod 4 equals 2*t + o mod 4
			s_yy    = {y[4], 1'b0} + y[1:0];
			s_cc    = {y[12], 1'b0} + y[9:8];
			yy_div4 = (s_yy == 2'd0);
			cc_div4 = (s_cc == 2'd0);
			yy_zero = (y[7:0] == 8'h00);
			bcd_leap = (yy_div4 && !yy_zero) || (yy_zero && cc_div4);
		end
	endfunction

	// days in month m (1..12) of year y
	function automatic logic [4:0] month_len(input year_bcd_t y, input logic [3:0] m);
		logic [4:0] len;
		begin
			case (m)
				4'd2:    len = bcd_leap(y) ? 5'd29 : 5'd28;
				4'd4,
				4'd6,
				4'd9,
				4'd11:   len = 5'd30;
				default: len = 5'd31;
			endcase
			month_len = len;
		end
	endfunction

	// bcd increment, carry out in the top bit
	function automatic logic [16:0] bcd_inc(input year_bcd_t y);
		logic carry;
		logic [15:0] res;
		logic [3:0] dig;
		begin
			carry = 1'b1;
			res   = '0;
			for (int i = 0; i < 4; i++) begin
				dig = y[4*i +: 4];
				if (carry && dig == 4'd9) begin
					res[4*i +: 4] = 4'd0;
				end else begin
					res[4*i +: 4] = dig + {3'd0, carry};
					carry = 1'b0;
				end
			end
			bcd_inc = {carry, res};
		end
	endfunction

	// value 0..31 as two ascii digits
	function automatic logic [15:0] two_digits(input logic [4:0] v);
		logic [1:0] t;
		logic [4:0] o;
		begin
			if (v >= 5'd30) begin
				t = 2'd3;
				o = v - 5'd30;
			end else if (v >= 5'd20) begin
				t = 2'd2;
				o = v - 5'd20;
			end else if (v >= 5'd10) begin
				t = 2'd1;
				o = v - 5'd10;
			end else begin
				t = 2'd0;
				o = v;
			end
			two_digits = {ASCII_ZERO | {6'd0, t}, ASCII_ZERO | {4'd0, o[3:0]}};
		end
	endfunction

endpackage

// File: src/cds_in_if.sv
interface cds_in_if;
	import cds_pkg::*;

	logic        valid;
	logic        ready;
	logic        op;
	logic [63:0] date_text;
	logic [3:0]  text_length;

	modport source (output valid, op, date_text, text_length, input ready);
	modport sink (input valid, op, date_text, text_length, output ready);

endinterface

// File: src/cds_out_if.sv
interface cds_out_if;
	import cds_pkg::*;

	logic        valid;
	logic        ready;
	logic [63:0] out_date_text;
	logic [4:0]  day_count;
	logic [1:0]  status;

	modport source (output valid, out_date_text, day_count, status, input ready);
	modport sink (input valid, out_date_text, day_count, status, output ready);

endinterface

// File: src/calendar_date_step.sv
// Gregorian date stepper: each beat on date_in carries an ASCII date (YYYYMMDD, or YYMMDD
// read as 19YY) and an operation, add one day or add one month (day clamped to the length
// of the next month), and gives one beat on date_out with the new date as eight ASCII
// digits, the calendar days moved and a status (0 ok, 1 bad input, 2 year past 9999; date
// and day count are zero on error). The block is a four-stage pipeline (parse, range check
// and step, year carry and clamp, text formatting into the output register): it takes a
// date in every cycle while date_out does not stall, and a result passes through the stage
// registers s1, s2, s3 and s4 in turn and is offered on date_out from s4.
// Each stage holds its beat while the one after it is full,
// so a stall on date_out fills the pipeline before date_in drops ready.
module calendar_date_step
	import cds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	cds_in_if.sink       date_in,
	cds_out_if.source    date_out
);

	// per-stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s4 = !valid_s4 || date_out.ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign date_in.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= date_in.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: character checks and field split
	logic [7:0]  ch [8];
	logic        fmt_ok;
	logic        len_ok;
	year_bcd_t   year_c;
	logic [6:0]  month_c;
	logic [6:0]  day_c;

	always_comb begin
		len_ok = (date_in.text_length == LEN_LONG) || (date_in.text_length == LEN_SHORT);
		for (int i = 0; i < 8; i++) begin
			if (date_in.text_length == LEN_SHORT) begin
				if (i == 0)      ch[i] = ASCII_ONE;
				else if (i == 1) ch[i] = ASCII_NINE;
				else             ch[i] = date_in.date_text[63 - 8*(i-2) -: 8];
			end else begin
				ch[i] = date_in.date_text[63 - 8*i -: 8];
			end
		end
		fmt_ok = len_ok;
		for (int i = 0; i < 8; i++) begin
			if (ch[i] < ASCII_ZERO || ch[i] > ASCII_NINE) fmt_ok = 1'b0;
		end
		year_c  = {ch[0][3:0], ch[1][3:0], ch[2][3:0], ch[3][3:0]};
		month_c = 7'(ch[4][3:0]) * 7'd10 + 7'(ch[5][3:0]);
		day_c   = 7'(ch[6][3:0]) * 7'd10 + 7'(ch[7][3:0]);
		// year of 1900 or later
		if (year_c[15:12] < 4'd1 || (year_c[15:12] == 4'd1 && year_c[11:8] != 4'd9))
			fmt_ok = 1'b0;
	end

	logic        ok_s1;
	logic        op_s1;
	year_bcd_t   year_s1;
	logic [6:0]  month_s1;
	logic [6:0]  day_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			ok_s1    <= fmt_ok;
			op_s1    <= date_in.op;
			year_s1  <= year_c;
			month_s1 <= month_c;
			day_s1   <= day_c;
		end
	end

	// stage 2: month and day range, step to the next date
	logic        ok_c2;
	logic [4:0]  mlen_c2;
	logic [4:0]  nm_c2;
	logic [4:0]  nd_c2;
	logic        carry_c2;

	always_comb begin
		mlen_c2 = month_len(year_s1, month_s1[3:0]);
		ok_c2   = ok_s1 && month_s1 >= 7'd1 && month_s1 <= 7'd12
			&& day_s1 >= 7'd1 && day_s1 <= 7'(mlen_c2);
		if (op_s1 == OP_ADD_DAY && day_s1[4:0] != mlen_c2) begin
			nm_c2 = month_s1[4:0];
			nd_c2 = day_s1[4:0] + 5'd1;
		end else begin
			nm_c2 = month_s1[4:0] + 5'd1;
			nd_c2 = (op_s1 == OP_ADD_DAY) ? 5'd1 : day_s1[4:0];
		end
		carry_c2 = (nm_c2 == 5'd13);
		if (carry_c2) nm_c2 = 5'd1;
	end

	logic        ok_s2;
	logic        op_s2;
	year_bcd_t   year_s2;
	logic [4:0]  day_s2;
	logic [4:0]  mlen_s2;
	logic [3:0]  nm_s2;
	logic [4:0]  nd_s2;
	logic        carry_s2;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			ok_s2    <= ok_c2;
			op_s2    <= op_s1;
			year_s2  <= year_s1;
			day_s2   <= day_s1[4:0];
			mlen_s2  <= mlen_c2;
			nm_s2    <= nm_c2[3:0];
			nd_s2    <= nd_c2;
			carry_s2 <= carry_c2;
		end
	end

	// stage 3: year carry, clamp and day count
	logic [16:0] inc_c3;
	year_bcd_t   ny_c3;
	logic        ovf_c3;
	logic [4:0]  nlen_c3;
	logic [4:0]  nd_c3;
	logic [5:0]  days_c3;
	logic [1:0]  status_c3;

	always_comb begin
		inc_c3  = bcd_inc(year_s2);
		ny_c3   = carry_s2 ? inc_c3[15:0] : year_s2;
		ovf_c3  = carry_s2 && inc_c3[16];
		nlen_c3 = month_len(ny_c3, nm_s2);
		nd_c3   = nd_s2;
		days_c3 = 6'd1;
		if (op_s2 == OP_ADD_MONTH) begin
			if (nd_s2 > nlen_c3) nd_c3 = nlen_c3;
			days_c3 = 6'(mlen_s2) - 6'(day_s2) + 6'(nd_c3);
		end
		if (!ok_s2)      status_c3 = STATUS_INVALID;
		else if (ovf_c3) status_c3 = STATUS_OVERFLOW;
		else             status_c3 = STATUS_OK;
	end

	logic [1:0]  status_s3;
	year_bcd_t   ny_s3;
	logic [3:0]  nm_s3;
	logic [4:0]  nd_s3;
	logic [4:0]  days_s3;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			status_s3 <= status_c3;
			ny_s3     <= ny_c3;
			nm_s3     <= nm_s2;
			nd_s3     <= nd_c3;
			days_s3   <= days_c3[4:0];
		end
	end

	// stage 4: ascii formatting into the output register
	logic [63:0] text_c4;

	always_comb begin
		text_c4 = {ASCII_ZERO | {4'd0, ny_s3[15:12]}, ASCII_ZERO | {4'd0, ny_s3[11:8]},
			ASCII_ZERO | {4'd0, ny_s3[7:4]}, ASCII_ZERO | {4'd0, ny_s3[3:0]},
			two_digits({1'b0, nm_s3}), two_digits(nd_s3)};
	end

	logic [63:0] text_s4;
	logic [4:0]  days_s4;
	logic [1:0]  status_s4;

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			status_s4 <= status_s3;
			text_s4   <= (status_s3 == STATUS_OK) ? text_c4 : 64'd0;
			days_s4   <= (status_s3 == STATUS_OK) ? days_s3 : 5'd0;
		end
	end

	assign date_out.valid         = valid_s4;
	assign date_out.out_date_text = text_s4;
	assign date_out.day_count     = days_s4;
	assign date_out.status        = status_s4;

	// checks
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (status_s4 == STATUS_OK || status_s4 == STATUS_INVALID
			|| status_s4 == STATUS_OVERFLOW))
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && status_s4 != STATUS_OK |-> text_s4 == 64'd0 && days_s4 == 5'd0)
		else $error("error result carries data");

	a_ok_days: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && status_s4 == STATUS_OK |-> days_s4 != 5'd0)
		else $error("good result with zero day count");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(year_s1))
		else $error("stalled first stage lost its beat");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cds_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 2000;
	localparam int unsigned RANDOM_DATES    = 1650;
	localparam int unsigned BACKLOG_AT      = 400;
	localparam int unsigned BACKLOG_CYCLES  = 150;
	localparam int unsigned DRAIN_CYCLES    = 16;

	typedef struct {
		logic        op;
		logic [63:0] text;
		logic [3:0]  chars;
	} date_request_t;

	typedef struct {
		logic [63:0] text;
		logic [4:0]  days;
		logic [1:0]  status;
	} date_result_t;

	logic clk;
	logic arst_n;

	cds_in_if  date_in ();
	cds_out_if date_out ();

	calendar_date_step uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_in),
		.date_out (date_out)
	);

	date_request_t dates_to_send[$];
	date_result_t  expected_results[$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned quiet_cycles;
	int unsigned send_gap;
	int unsigned recv_hold;
	bit          send_calm;
	bit          recv_calm;

	// gregorian leap rule
	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// n ascii decimal digits of v, last digit in the low byte
	function automatic logic [31:0] ascii_digits(int unsigned v, int unsigned n);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < n; i++) begin
			r[8*i +: 8] = ASCII_ZERO + 8'(v % 10);
			v = v / 10;
		end
		return r;
	endfunction

	// expected result of one date beat
	function automatic date_result_t step_date(logic op, logic [63:0] text, logic [3:0] chars);
		date_result_t r;
		int unsigned  num[3];
		int unsigned  width[3];
		int unsigned  pos;
		int unsigned  y, m, d, ny, nm, nd, days, mlen, nlen;
		logic [7:0]   c;
		bit           ok;
		r.text   = '0;
		r.days   = '0;
		r.status = STATUS_INVALID;
		if (chars == LEN_LONG) begin
			width = '{4, 2, 2};
		end else if (chars == LEN_SHORT) begin
			width = '{2, 2, 2};
		end else begin
			return r;
		end
		// digits of year, month and day in turn
		ok  = 1'b1;
		pos = 0;
		for (int f = 0; f < 3; f++) begin
			num[f] = 0;
			for (int i = 0; i < width[f]; i++) begin
				c = text[63 - 8*pos -: 8];
				if (c < ASCII_ZERO || c > ASCII_NINE)
					ok = 1'b0;
				num[f] = num[f] * 10 + (c - ASCII_ZERO);
				pos++;
			end
		end
		if (!ok)
			return r;
		y = num[0];
		if (chars == LEN_SHORT)
			y = y + 1900;
		m = num[1];
		d = num[2];
		if (y < 1900 || m < 1 || m > 12)
			return r;
		mlen = days_in_month(y, m);
		if (d < 1 || d > mlen)
			return r;
		// step forward
		ny = y;
		days = 1;
		if (op == OP_ADD_DAY) begin
			nm = m;
			nd = d + 1;
			if (nd > mlen) begin
				nd = 1;
				nm = m + 1;
			end
		end else begin
			nm = m + 1;
			nd = d;
		end
		if (nm > 12) begin
			nm = 1;
			ny = y + 1;
		end
		// clamp the day to the new month
		if (op == OP_ADD_MONTH) begin
			nlen = days_in_month(ny, nm);
			if (nd > nlen)
				nd = nlen;
			days = mlen - d + nd;
		end
		if (ny > 9999) begin
			r.status = STATUS_OVERFLOW;
			return r;
		end
		r.text   = {ascii_digits(ny, 4), 16'(ascii_digits(nm, 2)), 16'(ascii_digits(nd, 2))};
		r.days   = 5'(days);
		r.status = STATUS_OK;
		return r;
	endfunction

	// a character that is not a decimal digit
	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0:       c = ASCII_ZERO - 8'd1;
			1:       c = ASCII_NINE + 8'd1;
			default: begin
				c = 8'($urandom_range(0, 255));
				while (c >= ASCII_ZERO && c <= ASCII_NINE)
					c = 8'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	// random date beat: mostly well-formed dates, some broken, some noise
	function automatic date_request_t random_date();
		date_request_t it;
		int unsigned   kind, y, m, d, mlen, pos;
		bit            short_form;
		it.op    = 1'($urandom_range(0, 1));
		it.text  = {$urandom, $urandom};
		kind     = $urandom_range(0, 99);
		if (kind < 5) begin
			it.chars = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
			return it;
		end
		if (kind < 12) begin
			it.chars = 4'($urandom_range(0, 15));
			while (it.chars == LEN_LONG || it.chars == LEN_SHORT)
				it.chars = 4'($urandom_range(0, 15));
			return it;
		end
		short_form = ($urandom_range(0, 3) == 0);
		// year, weighted toward the edges and century years
		if (short_form) begin
			y = 1900 + $urandom_range(0, 99);
		end else begin
			case ($urandom_range(0, 9))
				0:       y = 9999;
				1:       y = 1900;
				2:       y = $urandom_range(19, 99) * 100;
				3:       y = 9998;
				default: y = $urandom_range(1900, 9999);
			endcase
		end
		m    = $urandom_range(1, 12);
		mlen = days_in_month(y, m);
		case ($urandom_range(0, 9))
			0, 1, 2: d = mlen;
			3:       d = mlen - 1;
			4:       d = 1;
			default: d = $urandom_range(1, mlen);
		endcase
		pos = 99;
		// broken dates
		if (kind < 25) begin
			case ($urandom_range(0, 5))
				0:       d = 0;
				1:       d = mlen + 1;
				2:       m = 0;
				3:       m = $urandom_range(13, 99);
				4:       if (short_form) pos = 0; else y = $urandom_range(0, 1899);
				default: pos = 0;
			endcase
		end
		if (short_form) begin
			it.chars       = LEN_SHORT;
			it.text[63:16] = {16'(ascii_digits(y % 100, 2)), 16'(ascii_digits(m, 2)),
				16'(ascii_digits(d, 2))};
		end else begin
			it.chars = LEN_LONG;
			it.text  = {ascii_digits(y, 4), 16'(ascii_digits(m, 2)), 16'(ascii_digits(d, 2))};
		end
		if (pos == 0) begin
			pos = $urandom_range(0, it.chars - 1);
			it.text[63 - 8*pos -: 8] = non_digit();
		end
		return it;
	endfunction

	// idle length: mostly short, a few long, none in calm stretches
	function automatic int unsigned idle_length(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pack_text(string s);
		logic [63:0] t;
		t = '0;
		for (int i = 0; i < s.len(); i++)
			t[63 - 8*i -: 8] = s[i];
		return t;
	endfunction

	task automatic queue_text(logic op, string s, logic [3:0] chars);
		date_request_t it;
		it.op    = op;
		it.text  = pack_text(s);
		it.chars = chars;
		dates_to_send.push_back(it);
	endtask

	// clock
	always #2 clk = ~clk;

	// sender: offers queued dates and predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin : sender
		date_request_t it;
		logic          next_valid;
		if (!arst_n) begin
			date_in.valid       <= 1'b0;
			date_in.op          <= OP_ADD_DAY;
			date_in.date_text   <= '0;
			date_in.text_length <= '0;
			send_gap = 0;
		end else begin
			next_valid = date_in.valid;
			if (date_in.valid && date_in.ready) begin
				expected_results.push_back(step_date(date_in.op, date_in.date_text,
					date_in.text_length));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if ($urandom_range(0, 63) == 0)
					send_calm = !send_calm;
				if (send_gap > 0) begin
					send_gap--;
				end else if (dates_to_send.size() != 0) begin
					it = dates_to_send.pop_front();
					date_in.op          <= it.op;
					date_in.date_text   <= it.text;
					date_in.text_length <= it.chars;
					next_valid = 1'b1;
					send_gap = idle_length(send_calm);
				end
			end
			date_in.valid <= next_valid;
		end
	end

	// receiver: checks each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : receiver
		date_result_t want;
		logic         next_ready;
		if (!arst_n) begin
			date_out.ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (date_out.valid && date_out.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with none pending: date %h days %0d status %0d",
						$time, date_out.out_date_text, date_out.day_count, date_out.status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (date_out.out_date_text !== want.text) begin
						$display("%0t: out_date_text expected %h actual %h",
							$time, want.text, date_out.out_date_text);
						mismatches++;
					end
					if (date_out.day_count !== want.days) begin
						$display("%0t: day_count expected %0d actual %0d",
							$time, want.days, date_out.day_count);
						mismatches++;
					end
					if (date_out.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, date_out.status);
						mismatches++;
					end
				end
				// one long hold-off so the pipeline backs up into date_in
				if (results_seen == BACKLOG_AT)
					recv_hold = BACKLOG_CYCLES;
				else
					recv_hold = idle_length(recv_calm);
			end else if (recv_hold == 0 && !recv_calm && $urandom_range(0, 15) == 0) begin
				recv_hold = idle_length(1'b0);
			end
			if ($urandom_range(0, 63) == 0)
				recv_calm = !recv_calm;
			if (recv_hold > 0) begin
				recv_hold--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			date_out.ready <= next_ready;
		end
	end

	// cycles without a beat on either side
	always @(posedge clk) begin
		if ((date_in.valid && date_in.ready) || (date_out.valid && date_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_CYCLES)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		date_in.valid       = 1'b0;
		date_in.op          = OP_ADD_DAY;
		date_in.date_text   = '0;
		date_in.text_length = '0;
		date_out.ready      = 1'b0;
		mismatches          = 0;
		results_seen        = 0;
		quiet_cycles        = 0;
		send_gap            = 0;
		recv_hold           = 0;
		send_calm           = 1'b0;
		recv_calm           = 1'b0;

		// year, leap and clamp corners
		queue_text(OP_ADD_DAY, "19991231", LEN_LONG);
		queue_text(OP_ADD_DAY, "20000228", LEN_LONG);
		queue_text(OP_ADD_DAY, "19000228", LEN_LONG);
		queue_text(OP_ADD_DAY, "21000228", LEN_LONG);
		queue_text(OP_ADD_DAY, "19000101", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20240131", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20230131", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20241231", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20240229", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20240331", LEN_LONG);
		queue_text(OP_ADD_MONTH, "99991130", LEN_LONG);
		// year overflow
		queue_text(OP_ADD_DAY, "99991231", LEN_LONG);
		queue_text(OP_ADD_MONTH, "99991215", LEN_LONG);
		// short form read as 19yy
		queue_text(OP_ADD_DAY, "991231", LEN_SHORT);
		queue_text(OP_ADD_MONTH, "000229", LEN_SHORT);
		// early year, bad month and day
		queue_text(OP_ADD_DAY, "18991231", LEN_LONG);
		queue_text(OP_ADD_DAY, "20241301", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20240001", LEN_LONG);
		queue_text(OP_ADD_DAY, "20240230", LEN_LONG);
		queue_text(OP_ADD_MONTH, "20240100", LEN_LONG);
		// non-digit characters and bad lengths
		queue_text(OP_ADD_DAY, "2024A101", LEN_LONG);
		queue_text(OP_ADD_DAY, "20240101", 4'd7);
		queue_text(OP_ADD_MONTH, "", 4'd0);
		queue_text(OP_ADD_DAY, "20240101", 4'd15);
		dates_to_send.push_back(date_request_t'{OP_ADD_MONTH, '1, LEN_LONG});

		for (int i = 0; i < RANDOM_DATES; i++)
			dates_to_send.push_back(random_date());

		repeat (6) @(posedge clk);
		#1 arst_n = 1'b1;

		// sample on the falling edge, once every process of the rising edge has settled
		while (dates_to_send.size() != 0 || date_in.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
src/cds_pkg.sv
src/cds_in_if.sv
src/cds_out_if.sv
src/calendar_date_step.sv
sim/testbench.sv
